FILE: src/nqcc_pkg.sv
// Shared types and constants for the N-queens constellation counter.
`default_nettype none

package nqcc_pkg;

  localparam int MASK_W  = 32;
  localparam int COUNT_W = 48;
  localparam int ROW_W   = 7;

  localparam logic [5:0]         BOARD_MIN   = 6'd5;
  localparam logic [5:0]         BOARD_RESET = 6'd16;
  localparam logic [MASK_W-1:0]  ALL_ONES    = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  typedef logic signed [ROW_W-1:0] row_t;

  // Terms from which every entry of the blocked-cell table is built.
  typedef struct packed {
    logic [5:0]        n;
    logic [4:0]        k;
    logic [4:0]        l;
    logic [MASK_W-1:0] lb;
    logic [MASK_W-1:0] bot_l;
    logic [MASK_W-1:0] bot_r;
    logic [MASK_W-1:0] top_l;
    logic [MASK_W-1:0] top_r;
  } nqcc_fill_t;

endpackage

`default_nettype wire

FILE: src/nqcc_table.sv
// Per-row blocked-cell table: fill value generator and synchronous memory.
`default_nettype none

module nqcc_table
  import nqcc_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic              clk,
  input  wire logic              fill_en,
  input  wire logic [AW-1:0]     fill_addr,
  input  wire nqcc_fill_t        fill,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [MASK_W-1:0] rd_data
);

  logic [MASK_W-1:0] mem [DEPTH];
  logic [4:0]        a5;
  logic [4:0]        sh;
  logic [MASK_W-1:0] fill_value;
  logic [MASK_W-1:0] k_term;
  logic [MASK_W-1:0] l_term;

  assign a5 = 5'(fill_addr);
  // Distance to the last row, wrapped to five bits like a barrel shifter.
  assign sh = fill.n[4:0] - 5'd1 - a5;
  assign k_term = (a5 == fill.k) ? ~fill.lb : '0;
  assign l_term = (a5 == fill.l) ? ~32'd1 : '0;

  always_comb begin
    if ({1'b0, a5} >= fill.n) begin
      fill_value = ALL_ONES;
    end else if (a5 == fill.k || a5 == fill.l) begin
      // Rows holding a border queen take the wrapped sum of both terms.
      fill_value = k_term + l_term;
    end else begin
      fill_value = (fill.bot_l >> sh) | (fill.bot_r << sh) | (fill.top_l << a5) |
                   (fill.top_r >> a5) | fill.lb | 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_en) begin
      mem[fill_addr] <= fill_value;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: src/nqcc_stack.sv
// Queen stack: one placed queen per row in a synchronous memory.
`default_nettype none

module nqcc_stack
  import nqcc_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [MASK_W-1:0] wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [MASK_W-1:0] rd_data
);

  logic [MASK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: src/nqcc_search.sv
// Backtracking search sequencer: decides each step and finishes it from memory data.
`default_nettype none

module nqcc_search
  import nqcc_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic [5:0]         n_in,
  input  wire logic [MASK_W-1:0]  left_diag_in,
  input  wire logic [MASK_W-1:0]  right_diag_in,
  input  wire logic [MASK_W-1:0]  column_in,
  input  wire logic [4:0]         start_in,
  input  wire logic [4:0]         j_in,
  input  wire logic [4:0]         k_in,
  input  wire logic [4:0]         l_in,
  output logic                    active,
  output logic                    done,
  output logic      [COUNT_W-1:0] count_out
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_FILL,
    S_INIT_RD,
    S_INIT,
    S_DECIDE,
    S_FINISH
  } state_t;

  state_t            state;
  nqcc_fill_t        fill;
  logic [4:0]        start;
  logic [4:0]        j;
  logic [MASK_W-1:0] ldm;
  logic [MASK_W-1:0] rdm;
  logic [MASK_W-1:0] colm;
  logic [AW-1:0]     fill_addr;
  logic [63:0]       ld;
  logic [63:0]       rd;
  logic [MASK_W-1:0] col;
  logic [MASK_W-1:0] fr;
  logic [MASK_W-1:0] queen;
  logic              fwd;
  row_t              row;
  logic              oob;
  logic [COUNT_W-1:0] count;

  logic [MASK_W-1:0] tbl_rdata;
  logic [MASK_W-1:0] stk_rdata;
  logic [AW-1:0]     tbl_raddr;
  logic              stk_we;
  logic [MASK_W-1:0] blk;
  logic [MASK_W-1:0] q_low;
  row_t              row_up;
  row_t              row_dn;
  row_t              row_next;
  row_t              start_row;
  row_t              n_row;
  logic [MASK_W-1:0] lb_calc;
  logic [MASK_W-1:0] q_fin;
  logic [63:0]       ld_fin;
  logic [63:0]       rd_fin;
  logic [MASK_W-1:0] fr_fin;

  assign start_row = row_t'({2'b00, start});
  assign n_row     = row_t'({1'b0, fill.n});
  assign row_up    = row + row_t'(1);
  assign row_dn    = row - row_t'(1);
  assign row_next  = (fr != '0) ? row_up : row_dn;
  assign q_low     = fr & (~fr + 32'd1);
  assign blk       = oob ? ALL_ONES : tbl_rdata;
  assign lb_calc   = 32'd1 << (fill.n[4:0] - 5'd1);

  assign q_fin  = fwd ? queen : stk_rdata;
  assign ld_fin = fwd ? ld : ((ld >> 1) ^ {32'b0, q_fin});
  assign rd_fin = fwd ? rd : ((rd << 1) ^ {q_fin, 32'b0});
  assign fr_fin = ~(blk | col | ld_fin[31:0] | rd_fin[63:32]) &
                  (fwd ? ~q_fin : ~(q_fin - 32'd1));

  always_comb begin
    case (state)
      S_INIT_RD: tbl_raddr = AW'(start);
      S_DECIDE:  tbl_raddr = row_next[AW-1:0];
      default:   tbl_raddr = '0;
    endcase
  end

  assign stk_we = (state == S_DECIDE) && (fr != '0);
  assign active = (state != S_IDLE);

  nqcc_table #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_table (
    .clk      (clk),
    .fill_en  (state == S_FILL),
    .fill_addr(fill_addr),
    .fill     (fill),
    .rd_addr  (tbl_raddr),
    .rd_data  (tbl_rdata)
  );

  // A forward step writes its row; a backtrack reads the row below in a later cycle,
  // so the write has always landed before the read that needs it.
  nqcc_stack #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_stack (
    .clk    (clk),
    .wr_en  (stk_we),
    .wr_addr(row[AW-1:0]),
    .wr_data(q_low),
    .rd_addr(row_dn[AW-1:0]),
    .rd_data(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      fill_addr <= '0;
      fwd       <= 1'b0;
      row       <= '0;
      oob       <= 1'b0;
      count     <= '0;
      ld        <= '0;
      rd        <= '0;
      col       <= '0;
      fr        <= '0;
      queen     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (go) begin
            fill.n <= n_in;
            fill.k <= k_in;
            fill.l <= l_in;
            start  <= start_in;
            j      <= j_in;
            ldm    <= left_diag_in;
            rdm    <= right_diag_in;
            colm   <= column_in;
            state  <= S_SETUP;
          end
        end
        S_SETUP: begin
          fill.lb    <= lb_calc;
          fill.bot_l <= (lb_calc >> j) | (lb_calc >> fill.l);
          fill.bot_r <= (lb_calc >> j) | (lb_calc >> (fill.n[4:0] - 5'd1 - fill.k));
          fill.top_l <= lb_calc >> fill.k;
          fill.top_r <= 32'd1 << fill.l;
          fill_addr  <= '0;
          state      <= S_FILL;
        end
        S_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          if (fill_addr == AW'(DEPTH - 1)) begin
            state <= S_INIT_RD;
          end
        end
        S_INIT_RD: begin
          ld  <= {32'b0, ldm & ~(fill.top_l << start)};
          // The right diagonals live in the upper half from here on.
          if ({1'b0, fill.l} != fill.n - 6'd1) begin
            rd <= {rdm & ~(fill.top_r >> start), 32'b0};
          end else begin
            rd <= {rdm, 32'b0};
          end
          col   <= ~(fill.lb - 32'd2) ^ colm;
          row   <= start_row;
          oob   <= (start_row >= n_row);
          count <= '0;
          state <= S_INIT;
        end
        S_INIT: begin
          fr    <= ~(col | blk | ld[31:0] | rd[63:32]);
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (fr != '0) begin
            fwd   <= 1'b1;
            queen <= q_low;
            ld    <= (ld | {32'b0, q_low}) << 1;
            rd    <= (rd | {q_low, 32'b0}) >> 1;
          end else begin
            fwd <= 1'b0;
          end
          row   <= row_next;
          oob   <= (row_next < row_t'(0)) || (row_next >= n_row);
          state <= S_FINISH;
        end
        S_FINISH: begin
          queen <= q_fin;
          ld    <= ld_fin;
          rd    <= rd_fin;
          fr    <= fr_fin;
          col   <= col ^ q_fin;
          if (row == n_row - row_t'(1) && count != COUNT_MAX) begin
            count     <= count + COUNT_W'(1);
            count_out <= count + COUNT_W'(1);
          end else begin
            count_out <= count;
          end
          if (row < start_row) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_DECIDE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/nqueens_constellation_counter_top.sv
// Top level of the N-queens constellation counter: board size register and request port.
//
// Each search step is one read of the table and stack memories and one update, so a step
// waits on the registered memory read before it can finish. One request at a time.
// A new request is taken in the cycle done is high. The result cannot be stalled.
// Reset (synchronous) returns to idle and sets board_size to 16; memories are not cleared.
`default_nettype none

module nqueens_constellation_counter_top
  import nqcc_pkg::*;
#(
  parameter int MAX_BOARD = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [5:0]         cfg_data,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [MASK_W-1:0]  left_diag_mask,
  input  wire logic [MASK_W-1:0]  right_diag_mask,
  input  wire logic [MASK_W-1:0]  column_mask,
  input  wire logic [4:0]         start_row,
  input  wire logic [4:0]         last_row_column,
  input  wire logic [4:0]         left_border_row,
  input  wire logic [4:0]         right_border_row,
  output logic                    done,
  output logic      [COUNT_W-1:0] solution_count
);

  localparam int DEPTH = MAX_BOARD;
  localparam int AW    = $clog2(MAX_BOARD);
  localparam logic [5:0] BOARD_MAX = 6'(MAX_BOARD);

  logic [5:0] board_size;
  logic [5:0] n_clamped;
  logic       active;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_size <= BOARD_RESET;
    end else if (cfg_write) begin
      board_size <= cfg_data;
    end
  end

  always_comb begin
    if (board_size < BOARD_MIN) begin
      n_clamped = BOARD_MIN;
    end else if (board_size > BOARD_MAX) begin
      n_clamped = BOARD_MAX;
    end else begin
      n_clamped = board_size;
    end
  end

  assign busy = active;

  nqcc_search #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_search (
    .clk          (clk),
    .rst          (rst),
    .go           (start && !active),
    .n_in         (n_clamped),
    .left_diag_in (left_diag_mask),
    .right_diag_in(right_diag_mask),
    .column_in    (column_mask),
    .start_in     (start_row),
    .j_in         (last_row_column),
    .k_in         (left_border_row),
    .l_in         (right_border_row),
    .active       (active),
    .done         (done),
    .count_out    (solution_count)
  );

endmodule

`default_nettype wire
